>>> src/run_length_byte_decoder_macros.svh
// ----------------------------------------------------------------------------
// Run-length byte decoder assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_BYTE_DECODER_MACROS_SVH
`define RUN_LENGTH_BYTE_DECODER_MACROS_SVH

// cond must hold at every clock edge out of reset
`define RLBD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rlbd assertion failed");

// cons must hold in the cycle after ante
`define RLBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlbd assertion failed");

`endif

>>> src/rlbd_pkg.sv
// ----------------------------------------------------------------------------
// Run-length byte decoder package
// Shared widths, limits and the run and push types.
// ----------------------------------------------------------------------------
`default_nettype none

package rlbd_pkg;

  localparam int unsigned MaxPixels = 65536;
  localparam int unsigned CountW    = 17;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  typedef struct packed {
    logic [7:0]        out_value;
    logic [CountW-1:0] run_length;
    logic              is_padding;
    logic              image_last;
  } run_t;

  typedef struct packed {
    logic [1:0] cnt;
    run_t       first;
    run_t       second;
  } push_t;

endpackage

`default_nettype wire

>>> src/rlbd_src_if.sv
// ----------------------------------------------------------------------------
// Source byte channel
// Valid/ready channel carrying one compressed byte and its end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlbd_src_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       source_end;

  modport source (output valid, output source_byte, output source_end, input ready);
  modport sink   (input valid, input source_byte, input source_end, output ready);
endinterface

`default_nettype wire

>>> src/rlbd_run_if.sv
// ----------------------------------------------------------------------------
// Output run channel
// Valid/ready channel carrying one decoded run.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlbd_run_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_value;
  logic [16:0] run_length;
  logic        is_padding;
  logic        image_last;

  modport source (output valid, output out_value, output run_length,
                  output is_padding, output image_last, input ready);
  modport sink   (input valid, input out_value, input run_length,
                  input is_padding, input image_last, output ready);
endinterface

`default_nettype wire

>>> src/rlbd_decode.sv
// ----------------------------------------------------------------------------
// Run-length byte decoder core
// Control word parsing, run clipping and padding for one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module rlbd_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                byte_i,
  input  logic                      end_i,
  input  logic [rlbd_pkg::CountW-1:0] limit_i,
  output rlbd_pkg::push_t           push_o
);
  import rlbd_pkg::*;

  typedef enum logic [1:0] {
    PhCtrlLo,
    PhCtrlHi,
    PhLiteral,
    PhRepeat
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [7:0]        ctrl_q, ctrl_d;
  logic [15:0]       rem_q, rem_d;
  logic [CountW-1:0] prod_q, prod_d;

  logic [15:0]       word;
  logic              active;
  logic              main_v;
  logic [7:0]        main_val;
  logic [CountW-1:0] len_raw;
  logic [CountW-1:0] left;
  logic [CountW-1:0] main_len;
  logic [CountW-1:0] prod_mid;
  logic              pad_v;
  run_t              main_run;
  run_t              pad_run;

  assign word   = {byte_i, ctrl_q};
  assign active = prod_q < limit_i;

  always_comb begin
    phase_d  = phase_q;
    ctrl_d   = ctrl_q;
    rem_d    = rem_q;
    main_v   = 1'b0;
    main_val = '0;
    len_raw  = '0;
    if (step_i && active) begin
      unique case (phase_q)
        PhCtrlLo: begin
          ctrl_d  = byte_i;
          phase_d = PhCtrlHi;
        end
        PhCtrlHi: begin
          if (word[15]) begin
            rem_d   = 16'(17'h10000 - {1'b0, word});
            phase_d = PhRepeat;
            if (end_i) begin
              main_v  = 1'b1;
              len_raw = {1'b0, rem_d} + CountW'(1);
            end
          end else begin
            rem_d   = word + 16'd1;
            phase_d = PhLiteral;
          end
        end
        PhLiteral: begin
          main_v   = 1'b1;
          main_val = byte_i;
          len_raw  = CountW'(1);
          rem_d    = rem_q - 16'd1;
          if (rem_q == 16'd1) begin
            phase_d = PhCtrlLo;
          end
        end
        PhRepeat: begin
          main_v   = 1'b1;
          main_val = byte_i;
          len_raw  = {1'b0, rem_q} + CountW'(1);
          rem_d    = '0;
          phase_d  = PhCtrlLo;
        end
      endcase
    end

    left     = limit_i - prod_q;
    main_len = (len_raw > left) ? left : len_raw;
    prod_mid = main_v ? (prod_q + main_len) : prod_q;
    pad_v    = step_i && end_i && (prod_mid < limit_i);

    main_run.out_value  = main_val;
    main_run.run_length = main_len;
    main_run.is_padding = 1'b0;
    main_run.image_last = (prod_mid == limit_i);

    pad_run.out_value  = '0;
    pad_run.run_length = limit_i - prod_mid;
    pad_run.is_padding = 1'b1;
    pad_run.image_last = 1'b1;

    prod_d = prod_mid;
    if (step_i && end_i) begin
      phase_d = PhCtrlLo;
      ctrl_d  = '0;
      rem_d   = '0;
      prod_d  = '0;
    end

    push_o.cnt    = 2'({1'b0, main_v} + {1'b0, pad_v});
    push_o.first  = main_v ? main_run : pad_run;
    push_o.second = pad_run;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhCtrlLo;
      ctrl_q  <= '0;
      rem_q   <= '0;
      prod_q  <= '0;
    end else begin
      phase_q <= phase_d;
      ctrl_q  <= ctrl_d;
      rem_q   <= rem_d;
      prod_q  <= prod_d;
    end
  end

endmodule

`default_nettype wire

>>> src/rlbd_run_fifo.sv
// ----------------------------------------------------------------------------
// Run-length byte decoder result queue
// Four-entry queue: up to two runs in and, when ready_i, one out per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rlbd_run_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rlbd_pkg::push_t push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output rlbd_pkg::run_t  run_o
);
  import rlbd_pkg::*;

  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  run_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                pop;
  logic [FifoPtrW-1:0] wptr_nx;

  assign valid_o = cnt_q != '0;
  assign run_o   = mem_q[rptr_q];
  assign room_o  = cnt_q <= CntW'(FifoDepth - 2);
  assign pop     = valid_o && ready_i;
  assign wptr_nx = wptr_q + FifoPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wptr_nx] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + FifoPtrW'(push_i.cnt);
      if (pop) begin
        rptr_q <= rptr_q + FifoPtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i.cnt) - CntW'(pop);
    end
  end

endmodule

`default_nettype wire

>>> src/run_length_byte_decoder.sv
// ----------------------------------------------------------------------------
// Run-length byte decoder
// Decodes a byte stream with 16-bit signed control words into value runs.
// ----------------------------------------------------------------------------
// Usage: feed one compressed byte per request on src_i, with source_end set
// on the last byte of an image. Decoded runs leave on run_o as value, length,
// padding flag and last flag; image_last marks the run completing the image.
// cfg_we_i/cfg_wdata_i set the pixel count; write it while the block is idle.
// Each byte is registered, then its runs are queued before reaching run_o.
// Throughput: one byte per cycle while the result queue has room; the last
// byte may push a run and a padding run, which the four-entry queue absorbs.
// src_i.ready falls only when the result queue has fewer than two free slots
// and a byte is already held in the input register; a stalled run_o fills the
// queue and then holds the input side.
// Reset clears the decode state, empties the queue and sets the pixel count
// to 65536.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_byte_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rlbd_pkg::CountW-1:0]   cfg_wdata_i,
  rlbd_src_if.sink                      src_i,
  rlbd_run_if.source                    run_o
);
  import rlbd_pkg::*;

  logic              in_v_q;
  logic [7:0]        in_byte_q;
  logic              in_end_q;
  logic [CountW-1:0] limit_q;
  logic              room;
  logic              step;
  logic              take;
  push_t             push;
  run_t              run;

  assign step        = in_v_q && room;
  assign src_i.ready = !in_v_q || room;
  assign take        = src_i.valid && src_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      limit_q <= CountW'(MaxPixels);
    end else begin
      if (take) begin
        in_v_q <= 1'b1;
      end else if (step) begin
        in_v_q <= 1'b0;
      end
      if (cfg_we_i) begin
        if (cfg_wdata_i == '0) begin
          limit_q <= CountW'(1);
        end else if (cfg_wdata_i > CountW'(MaxPixels)) begin
          limit_q <= CountW'(MaxPixels);
        end else begin
          limit_q <= cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= src_i.source_byte;
      in_end_q  <= src_i.source_end;
    end
  end

  rlbd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .end_i   (in_end_q),
    .limit_i (limit_q),
    .push_o  (push)
  );

  rlbd_run_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (run_o.valid),
    .ready_i (run_o.ready),
    .run_o   (run)
  );

  assign run_o.out_value  = run.out_value;
  assign run_o.run_length = run.run_length;
  assign run_o.is_padding = run.is_padding;
  assign run_o.image_last = run.image_last;

endmodule

`default_nettype wire

>>> src/rlbd_checker.sv
// ----------------------------------------------------------------------------
// Run-length byte decoder port checker
// Checks run channel behaviour seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "run_length_byte_decoder_macros.svh"

module rlbd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        run_valid_i,
  input  logic        run_ready_i,
  input  logic [16:0] run_length_i,
  input  logic        is_padding_i,
  input  logic        image_last_i
);

  `RLBD_ASSERT_NEXT(a_run_hold, clk_i, rst_ni, run_valid_i && !run_ready_i, run_valid_i)
  `RLBD_ASSERT_ALWAYS(a_len_nonzero, clk_i, rst_ni, !run_valid_i || (run_length_i != 17'd0))
  `RLBD_ASSERT_ALWAYS(a_len_max, clk_i, rst_ni, !run_valid_i || !run_length_i[16] || (run_length_i[15:0] == 16'd0))
  `RLBD_ASSERT_ALWAYS(a_pad_last, clk_i, rst_ni, !run_valid_i || !is_padding_i || image_last_i)

endmodule

bind run_length_byte_decoder rlbd_checker u_rlbd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .run_valid_i  (run_o.valid),
  .run_ready_i  (run_o.ready),
  .run_length_i (run_o.run_length),
  .is_padding_i (run_o.is_padding),
  .image_last_i (run_o.image_last)
);

`default_nettype wire
